// ===== design/cfse_pkg.sv =====
package cfse_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] REG_INDEX_REAL  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_EXTINCTION  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_REFL_RED    = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_REFL_GREEN  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_REFL_BLUE   = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_MIRROR_TOL  = 3'd5;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [15:0] CHANNEL_MAX = 16'h8000;

  // Stage layout of the pipeline.
  localparam int StLoad   = 0;
  localparam int StDot    = 1;
  localparam int StSquare = 2;
  localparam int StTerm   = 3;
  localparam int StRad    = 4;
  localparam int Sq1First = 5;
  localparam int Sq1Bits  = 26;
  localparam int StHalf   = Sq1First + Sq1Bits;
  localparam int Sq2First = StHalf + 1;
  localparam int Sq2Bits  = 21;
  localparam int StProd   = Sq2First + Sq2Bits;
  localparam int StDiv1   = StProd + 1;
  localparam int Dv1First = StDiv1 + 1;
  localparam int QuoBits  = 17;
  localparam int StRs     = Dv1First + QuoBits;
  localparam int Dv2First = StRs + 1;
  localparam int StFres   = Dv2First + QuoBits;
  localparam int StOut    = StFres + 1;
  localparam int NumSt    = StOut + 1;

  typedef struct packed {
    logic               func;
    logic               ok;
    logic               lz_pos;
    logic               vz_pos;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [15:0] mx;
    logic        [15:0] my;
    logic        [15:0] mz;
    logic        [16:0] c;
    logic        [16:0] c2;
    logic        [16:0] s2;
    logic        [16:0] s4;
    logic        [23:0] e2;
    logic        [23:0] k2;
    logic signed [25:0] t1;
    logic        [49:0] at1sq;
    logic        [49:0] ek4;
    logic        [55:0] rem;
    logic        [25:0] root;
    logic        [25:0] ab;
    logic        [26:0] t1sum;
    logic        [21:0] t2;
    logic        [26:0] abc2;
    logic        [27:0] t3;
    logic        [21:0] t4;
    logic        [47:0] drem;
    logic        [28:0] dden;
    logic        [16:0] quo;
    logic        [16:0] rs;
    logic        [32:0] pr;
    logic        [32:0] pg;
    logic        [32:0] pb;
    logic        [15:0] ored;
    logic        [15:0] ogreen;
    logic        [15:0] oblue;
  } stage_t;

endpackage

// ===== design/cfse_if.sv =====
interface cfse_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] light_x;
  logic signed [15:0] light_y;
  logic signed [15:0] light_z;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;

  modport source (output valid, func, light_x, light_y, light_z, view_x, view_y, view_z,
                  input ready);
  modport sink (input valid, func, light_x, light_y, light_z, view_x, view_y, view_z,
                output ready);
endinterface

interface cfse_rsp_if;
  logic               valid;
  logic               ready;
  logic        [15:0] red;
  logic        [15:0] green;
  logic        [15:0] blue;
  logic signed [15:0] mirror_x;
  logic signed [15:0] mirror_y;
  logic signed [15:0] mirror_z;
  logic               valid_res;

  modport source (output valid, red, green, blue, mirror_x, mirror_y, mirror_z, valid_res,
                  input ready);
  modport sink (input valid, red, green, blue, mirror_x, mirror_y, mirror_z, valid_res,
                output ready);
endinterface

// ===== design/conductor_fresnel_specular_eval.sv =====
// Throughput: one word per cycle while the output is not stalled; the two bit-serial
// square roots and the two restoring dividers are unrolled into one stage per result bit.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the stage valid bits and loads the register defaults.
module conductor_fresnel_specular_eval #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cfse_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [cfse_pkg::CfgDataW-1:0]  cfg_data,
  cfse_req_if.sink                       req,
  cfse_rsp_if.source                     rsp
);

  localparam int NST = cfse_pkg::NumSt;
  localparam int DW  = ((2 * DIR_FRAC_BITS + 2 > 34) ? 2 * DIR_FRAC_BITS + 2 : 34) + 2;
  localparam int SR  = (DIR_FRAC_BITS >= 16) ? DIR_FRAC_BITS - 16 : 0;
  localparam int SL  = (DIR_FRAC_BITS < 16) ? 16 - DIR_FRAC_BITS : 0;
  localparam logic signed [DW-1:0] ONE2 = DW'(1) << (2 * DIR_FRAC_BITS);

  logic [15:0] index_real;
  logic [15:0] extinction;
  logic [15:0] refl_red;
  logic [15:0] refl_green;
  logic [15:0] refl_blue;
  logic [14:0] mirror_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_real       <= 16'd0;
      extinction       <= 16'd4096;
      refl_red         <= 16'd32768;
      refl_green       <= 16'd32768;
      refl_blue        <= 16'd32768;
      mirror_tolerance <= 15'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cfse_pkg::REG_INDEX_REAL: index_real       <= cfg_data;
        cfse_pkg::REG_EXTINCTION: extinction       <= cfg_data;
        cfse_pkg::REG_REFL_RED:   refl_red         <= cfg_data;
        cfse_pkg::REG_REFL_GREEN: refl_green       <= cfg_data;
        cfse_pkg::REG_REFL_BLUE:  refl_blue        <= cfg_data;
        cfse_pkg::REG_MIRROR_TOL: mirror_tolerance <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  cfse_pkg::stage_t st [NST];
  logic [NST-1:0]   vld;
  logic             en;

  assign en        = !vld[NST-1] || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    cfse_pkg::stage_t nxt;

    if (k == cfse_pkg::StLoad) begin : g_load
      always_comb begin
        logic [31:0] lzw;
        logic [31:0] cw;
        nxt        = '0;
        nxt.func   = req.func;
        nxt.px     = req.light_x * req.view_x;
        nxt.py     = req.light_y * req.view_y;
        nxt.pz     = req.light_z * req.view_z;
        nxt.lz_pos = req.light_z > 16'sd0;
        nxt.vz_pos = req.view_z > 16'sd0;
        nxt.mx     = 16'd0 - 16'(req.light_x);
        nxt.my     = 16'd0 - 16'(req.light_y);
        nxt.mz     = 16'(req.light_z);
        lzw        = {17'd0, req.light_z[14:0]};
        if (DIR_FRAC_BITS >= 16) begin
          cw = lzw >> SR;
        end else begin
          cw = lzw << SL;
        end
        nxt.c = (cw > 32'(cfse_pkg::ONE_Q16)) ? cfse_pkg::ONE_Q16 : cw[16:0];
      end
    end else if (k == cfse_pkg::StDot) begin : g_dot
      always_comb begin
        logic signed [DW-1:0] dot;
        logic signed [DW-1:0] diff;
        logic        [DW-1:0] adiff;
        logic        [DW-1:0] tol;
        logic        [33:0]   cc;
        nxt   = st[k-1];
        dot   = DW'(st[k-1].pz) - DW'(st[k-1].px) - DW'(st[k-1].py);
        diff  = dot - ONE2;
        adiff = (diff < 0) ? DW'(-diff) : DW'(diff);
        tol   = DW'(mirror_tolerance) << DIR_FRAC_BITS;
        nxt.ok = st[k-1].func ? st[k-1].lz_pos
                              : (st[k-1].lz_pos && st[k-1].vz_pos && adiff <= tol);
        cc     = st[k-1].c * st[k-1].c;
        nxt.c2 = cc[32:16];
      end
    end else if (k == cfse_pkg::StSquare) begin : g_square
      always_comb begin
        logic [16:0] s2;
        logic [33:0] ss;
        logic [31:0] ee;
        logic [31:0] kk;
        nxt    = st[k-1];
        s2     = cfse_pkg::ONE_Q16 - st[k-1].c2;
        ss     = s2 * s2;
        ee     = index_real * index_real;
        kk     = extinction * extinction;
        nxt.s2 = s2;
        nxt.s4 = ss[32:16];
        nxt.e2 = ee[31:8];
        nxt.k2 = kk[31:8];
      end
    end else if (k == cfse_pkg::StTerm) begin : g_term
      always_comb begin
        logic signed [25:0] t1;
        logic        [24:0] at1;
        logic        [47:0] ek;
        nxt       = st[k-1];
        t1        = $signed({2'b00, st[k-1].e2}) - $signed({2'b00, st[k-1].k2})
                  - $signed({9'd0, st[k-1].s2});
        at1       = (t1 < 0) ? 25'(-t1) : 25'(t1);
        ek        = st[k-1].e2 * st[k-1].k2;
        nxt.t1    = t1;
        nxt.at1sq = at1 * at1;
        nxt.ek4   = {ek, 2'b00};
      end
    end else if (k == cfse_pkg::StRad) begin : g_rad
      always_comb begin
        nxt      = st[k-1];
        nxt.rem  = 56'(st[k-1].at1sq) + 56'(st[k-1].ek4);
        nxt.root = '0;
      end
    end else if ((k >= cfse_pkg::Sq1First && k < cfse_pkg::StHalf) ||
                 (k >= cfse_pkg::Sq2First && k < cfse_pkg::StProd)) begin : g_sqrt
      // One result bit per stage: keep rem = x - root^2 and try root + 2^b.
      localparam int B = (k < cfse_pkg::StHalf)
                       ? cfse_pkg::Sq1Bits - 1 - (k - cfse_pkg::Sq1First)
                       : cfse_pkg::Sq2Bits - 1 - (k - cfse_pkg::Sq2First);
      always_comb begin
        logic [55:0] cand;
        nxt  = st[k-1];
        cand = (56'(st[k-1].root) << (B + 1)) + (56'(1) << (2 * B));
        if (st[k-1].rem >= cand) begin
          nxt.rem  = st[k-1].rem - cand;
          nxt.root = st[k-1].root | (26'(1) << B);
        end
      end
    end else if (k == cfse_pkg::StHalf) begin : g_half
      always_comb begin
        logic signed [27:0] half;
        logic        [24:0] hx;
        nxt       = st[k-1];
        nxt.ab    = st[k-1].root;
        nxt.t1sum = 27'(st[k-1].root) + 27'(st[k-1].c2);
        half      = $signed({2'b00, st[k-1].root}) + 28'(st[k-1].t1);
        hx        = (half > 0) ? half[25:1] : 25'd0;
        nxt.rem   = 56'(hx) << 16;
        nxt.root  = '0;
      end
    end else if (k == cfse_pkg::StProd) begin : g_prod
      always_comb begin
        logic [37:0] ac;
        logic [42:0] abc;
        nxt      = st[k-1];
        ac       = st[k-1].root[20:0] * st[k-1].c;
        abc      = st[k-1].ab * st[k-1].c2;
        nxt.t2   = ac[36:15];
        nxt.abc2 = abc[42:16];
      end
    end else if (k == cfse_pkg::StDiv1) begin : g_div1
      always_comb begin
        logic [38:0] tt;
        nxt      = st[k-1];
        nxt.dden = 29'(st[k-1].t1sum) + 29'(st[k-1].t2);
        nxt.drem = (st[k-1].t1sum > 27'(st[k-1].t2))
                 ? 48'(st[k-1].t1sum - 27'(st[k-1].t2)) << 16 : 48'd0;
        nxt.quo  = '0;
        tt       = st[k-1].t2 * st[k-1].s2;
        nxt.t3   = 28'(st[k-1].abc2) + 28'(st[k-1].s4);
        nxt.t4   = tt[37:16];
      end
    end else if ((k >= cfse_pkg::Dv1First && k < cfse_pkg::StRs) ||
                 (k >= cfse_pkg::Dv2First && k < cfse_pkg::StFres)) begin : g_div
      localparam int Q = (k < cfse_pkg::StRs)
                       ? cfse_pkg::QuoBits - 1 - (k - cfse_pkg::Dv1First)
                       : cfse_pkg::QuoBits - 1 - (k - cfse_pkg::Dv2First);
      always_comb begin
        logic [47:0] sd;
        nxt = st[k-1];
        sd  = 48'(st[k-1].dden) << Q;
        if (st[k-1].drem >= sd) begin
          nxt.drem = st[k-1].drem - sd;
          nxt.quo  = st[k-1].quo | (17'(1) << Q);
        end
      end
    end else if (k == cfse_pkg::StRs) begin : g_rs
      always_comb begin
        logic [16:0] rs;
        logic [27:0] m;
        nxt      = st[k-1];
        // A zero denominator means full reflection.
        rs       = (st[k-1].dden == '0) ? cfse_pkg::ONE_Q16 : st[k-1].quo;
        m        = (st[k-1].t3 > 28'(st[k-1].t4)) ? st[k-1].t3 - 28'(st[k-1].t4) : 28'd0;
        nxt.rs   = rs;
        nxt.drem = 48'(rs) * 48'(m);
        nxt.dden = 29'(st[k-1].t3) + 29'(st[k-1].t4);
        nxt.quo  = '0;
      end
    end else if (k == cfse_pkg::StFres) begin : g_fres
      always_comb begin
        logic [16:0] rp;
        logic [17:0] fs;
        nxt    = st[k-1];
        rp     = (st[k-1].dden == '0) ? st[k-1].rs : st[k-1].quo;
        fs     = 18'(st[k-1].rs) + 18'(rp);
        nxt.pr = refl_red * fs[17:1];
        nxt.pg = refl_green * fs[17:1];
        nxt.pb = refl_blue * fs[17:1];
      end
    end else begin : g_out
      always_comb begin
        logic [16:0] vr;
        logic [16:0] vg;
        logic [16:0] vb;
        logic        smp;
        nxt        = st[k-1];
        vr         = st[k-1].pr[32:16];
        vg         = st[k-1].pg[32:16];
        vb         = st[k-1].pb[32:16];
        smp        = st[k-1].ok && st[k-1].func;
        nxt.ored   = !st[k-1].ok ? 16'd0
                   : (vr > 17'(cfse_pkg::CHANNEL_MAX)) ? cfse_pkg::CHANNEL_MAX : vr[15:0];
        nxt.ogreen = !st[k-1].ok ? 16'd0
                   : (vg > 17'(cfse_pkg::CHANNEL_MAX)) ? cfse_pkg::CHANNEL_MAX : vg[15:0];
        nxt.oblue  = !st[k-1].ok ? 16'd0
                   : (vb > 17'(cfse_pkg::CHANNEL_MAX)) ? cfse_pkg::CHANNEL_MAX : vb[15:0];
        nxt.mx     = smp ? st[k-1].mx : 16'd0;
        nxt.my     = smp ? st[k-1].my : 16'd0;
        nxt.mz     = smp ? st[k-1].mz : 16'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign rsp.valid     = vld[NST-1];
  assign rsp.red       = st[NST-1].ored;
  assign rsp.green     = st[NST-1].ogreen;
  assign rsp.blue      = st[NST-1].oblue;
  assign rsp.mirror_x  = $signed(st[NST-1].mx);
  assign rsp.mirror_y  = $signed(st[NST-1].my);
  assign rsp.mirror_z  = $signed(st[NST-1].mz);
  assign rsp.valid_res = st[NST-1].ok;

endmodule

// ===== sim/tb_conductor_fresnel_specular_eval.sv =====
`timescale 1ns / 100ps

module tb_conductor_fresnel_specular_eval;

  localparam int FracBits   = 14;
  localparam int Latency    = 92;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic        [15:0] red;
    logic        [15:0] green;
    logic        [15:0] blue;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic               ok;
  } shade_t;

  typedef struct packed {
    logic               func;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } query_t;

  typedef struct {
    query_t q;
    logic   known;
    shade_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [cfse_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [cfse_pkg::CfgDataW-1:0]  cfg_data = '0;

  cfse_req_if req ();
  cfse_rsp_if rsp ();

  conductor_fresnel_specular_eval dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the registers.
  logic [15:0] eta, kext, alb_r, alb_g, alb_b;
  logic [14:0] tol;

  shade_t shade_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int quiet_pct = 33;
  bit hold_rsp = 1'b0;
  bit stall_go = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned conductor_fresnel(longint unsigned c);
    longint unsigned c2, s2, s4, e2, k2, at1, ab, hx, a, t1s, t2s, t3s, t4s, rs, rp, den;
    longint t1, half;
    c2 = (c * c) >> 16;
    s2 = 65536 - c2;
    s4 = (s2 * s2) >> 16;
    e2 = (longint'(eta) * eta) >> 8;
    k2 = (longint'(kext) * kext) >> 8;
    t1 = longint'(e2) - longint'(k2) - longint'(s2);
    at1 = t1 < 0 ? -t1 : t1;
    ab = root64(at1 * at1 + 4 * e2 * k2);
    half = longint'(ab) + t1;
    hx = half > 0 ? half >> 1 : 0;
    a = root64(hx << 16);
    t1s = ab + c2;
    t2s = (2 * a * c) >> 16;
    den = t1s + t2s;
    rs = den != 0 ? (((t1s > t2s) ? t1s - t2s : 0) << 16) / den : 65536;
    t3s = ((ab * c2) >> 16) + s4;
    t4s = (t2s * s2) >> 16;
    den = t3s + t4s;
    rp = den != 0 ? (rs * ((t3s > t4s) ? t3s - t4s : 0)) / den : rs;
    return (rs + rp) >> 1;
  endfunction

  function automatic logic [15:0] albedo_scale(logic [15:0] alb, longint unsigned f);
    longint unsigned v;
    v = (longint'(alb) * f) >> 16;
    return v > 32768 ? 16'h8000 : v[15:0];
  endfunction

  function automatic shade_t predict_shade(query_t q);
    shade_t s;
    longint dot, diff;
    longint unsigned c, f;
    logic ok;
    s = '0;
    if (q.func) begin
      ok = q.lz > 0;
    end else begin
      dot = -longint'(q.lx) * q.vx - longint'(q.ly) * q.vy + longint'(q.lz) * q.vz;
      diff = dot - (64'sd1 << (2 * FracBits));
      if (diff < 0) diff = -diff;
      ok = q.lz > 0 && q.vz > 0 && diff <= longint'(tol) * (64'sd1 << FracBits);
    end
    if (ok) begin
      c = longint'(q.lz) << (16 - FracBits);
      if (c > 65536) c = 65536;
      f = conductor_fresnel(c);
      s.red = albedo_scale(alb_r, f);
      s.green = albedo_scale(alb_g, f);
      s.blue = albedo_scale(alb_b, f);
      if (q.func) begin
        s.mx = -q.lx;
        s.my = -q.ly;
        s.mz = q.lz;
      end
      s.ok = 1'b1;
    end
    return s;
  endfunction

  task automatic write_reg(logic [cfse_pkg::CfgIndexW-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cfse_pkg::REG_INDEX_REAL: eta = val;
      cfse_pkg::REG_EXTINCTION: kext = val;
      cfse_pkg::REG_REFL_RED:   alb_r = val;
      cfse_pkg::REG_REFL_GREEN: alb_g = val;
      cfse_pkg::REG_REFL_BLUE:  alb_b = val;
      cfse_pkg::REG_MIRROR_TOL: tol = val[14:0];
      default: ;
    endcase
  endtask

  // Only one request is in flight per call; valid is left high on a back-to-back send.
  task automatic send_query(query_t q, logic known, shade_t want);
    while ($urandom_range(99) < quiet_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    {req.func, req.light_x, req.light_y, req.light_z, req.view_x, req.view_y, req.view_z} <= q;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    shade_queue.push_back(known ? want : predict_shade(q));
  endtask

  task automatic drain_pipe();
    req.valid <= 1'b0;
    while (shade_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh4000;
      1: return -16'sh4000;
      2: return 16'($urandom);
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int pick;
    q.func = 1'($urandom_range(1));
    q.lx = rand_comp();
    q.ly = rand_comp();
    q.lz = 16'($urandom_range(16384));
    pick = $urandom_range(9);
    if (pick < 6) begin
      // Exact mirror, occasionally nudged by a small amount.
      q.vx = -q.lx;
      q.vy = -q.ly;
      q.vz = q.lz;
      if (pick == 5) q.vz = q.vz + $signed(16'($urandom_range(8))) - 16'sd4;
      if (pick == 4) begin
        q.lx = 16'($urandom_range(16384)) - 16'sd8192;
        q.ly = 16'($urandom_range(8000)) - 16'sd4000;
        q.lz = 16'(root64(64'd268435456 - longint'(q.lx) * q.lx - longint'(q.ly) * q.ly));
        q.vx = -q.lx;
        q.vy = -q.ly;
        q.vz = q.lz;
      end
    end else begin
      q.vx = rand_comp();
      q.vy = rand_comp();
      q.vz = rand_comp();
      if (pick == 9) q.lz = rand_comp();
    end
    return q;
  endfunction

  vector_t directed[$];

  function automatic vector_t row(query_t q, logic known, shade_t want);
    vector_t v;
    v.q = q;
    v.known = known;
    v.want = want;
    return v;
  endfunction

  initial begin
    req.valid = 1'b0;
    {req.func, req.light_x, req.light_y, req.light_z, req.view_x, req.view_y, req.view_z} = '0;
    eta = 16'd0;
    kext = 16'd4096;
    alb_r = 16'h8000;
    alb_g = 16'h8000;
    alb_b = 16'h8000;
    tol = 15'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rejections (non-positive cosines, failed mirror test) have known zero results.
    directed.push_back(row({1'b1, 16'sd100, -16'sd100, 16'sd0, 48'd0}, 1, '0));
    directed.push_back(row({1'b1, 16'sd0, 16'sd0, -16'sd16384, 48'd0}, 1, '0));
    directed.push_back(row({1'b0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384},
                           1, '0));
    directed.push_back(row({1'b0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd8000},
                           1, '0));
    directed.push_back(row({1'b0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384},
                           1, '0));
    // Normal incidence, exact mirror, sample extremes, negation wrap, cosine above one.
    directed.push_back(row({1'b0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384},
                           0, '0));
    directed.push_back(row({1'b1, 16'sd16384, -16'sd16384, 16'sd16384, 48'd0}, 0, '0));
    directed.push_back(row({1'b1, 16'sh8000, 16'sh7fff, 16'sd1, 48'd0}, 0, '0));
    directed.push_back(row({1'b1, 16'sd0, 16'sd0, 16'sh7fff, 48'd0}, 0, '0));
    directed.push_back(row({1'b0, 16'sd9459, 16'sd9459, 16'sd9459,
                            -16'sd9459, -16'sd9459, 16'sd9459}, 0, '0));
    directed.push_back(row({1'b0, -16'sd16384, 16'sd0, 16'sd1, 16'sd16384, 16'sd0, 16'sd1},
                           0, '0));
    directed.push_back(row({1'b1, 16'sh5555, 16'shaaaa, 16'sh2aaa, 48'hffff_0000_ffff},
                           0, '0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(cfse_pkg::REG_INDEX_REAL, 16'hffff);
          write_reg(cfse_pkg::REG_EXTINCTION, 16'h0000);
          write_reg(cfse_pkg::REG_MIRROR_TOL, 16'h4000);
        end
        2: begin
          write_reg(cfse_pkg::REG_INDEX_REAL, 16'd0);
          write_reg(cfse_pkg::REG_EXTINCTION, 16'd0);
          write_reg(cfse_pkg::REG_REFL_RED, 16'hffff);
          write_reg(cfse_pkg::REG_REFL_GREEN, 16'd0);
          write_reg(cfse_pkg::REG_REFL_BLUE, 16'h4000);
          write_reg(cfse_pkg::REG_MIRROR_TOL, 16'h7fff);
        end
        3: begin
          write_reg(cfse_pkg::REG_INDEX_REAL, 16'hffff);
          write_reg(cfse_pkg::REG_EXTINCTION, 16'hffff);
          write_reg(cfse_pkg::REG_MIRROR_TOL, 16'd0);
        end
        default: begin
          write_reg(cfse_pkg::REG_INDEX_REAL, 16'($urandom));
          write_reg(cfse_pkg::REG_EXTINCTION, 16'($urandom));
          write_reg(cfse_pkg::REG_REFL_RED, 16'($urandom_range(32768)));
          write_reg(cfse_pkg::REG_REFL_GREEN, 16'($urandom_range(32768)));
          write_reg(cfse_pkg::REG_REFL_BLUE, 16'($urandom));
          write_reg(cfse_pkg::REG_MIRROR_TOL, 16'($urandom_range(64)));
        end
      endcase
      if (ph == 0) begin
        foreach (directed[i]) send_query(directed[i].q, directed[i].known, directed[i].want);
      end
      quiet_pct = (ph == 4) ? 0 : 33;
      for (int n = 0; n < 140; n++) begin
        // Let the receiver hold off while plenty of words are still to come.
        if (ph == 3 && n == 20) stall_go = 1'b1;
        send_query(random_query(), 0, '0);
      end
      drain_pipe();
    end
    stim_done = 1'b1;
  end

  // Response side: random stalls, one long hold-off, and a stretch always ready.
  initial begin
    int cyc;
    int hold_cnt;
    cyc = 0;
    hold_cnt = 0;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (stall_go && !hold_rsp && hold_cnt == 0) hold_rsp = 1'b1;
      if (hold_rsp) begin
        hold_cnt++;
        if (hold_cnt == HoldCycles) hold_rsp = 1'b0;
      end
      if (hold_rsp) rsp.ready <= 1'b0;
      else if (cyc > 2000 && cyc < 2600) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    shade_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.red, rsp.green, rsp.blue, rsp.mirror_x, rsp.mirror_y, rsp.mirror_z,
             rsp.valid_res};
      if (shade_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %h", got);
      end else begin
        want = shade_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp r%0d g%0d b%0d m%0d,%0d,%0d v%0b",
                     want.red, want.green, want.blue, want.mx, want.my, want.mz, want.ok);
            $display("          got r%0d g%0d b%0d m%0d,%0d,%0d v%0b",
                     got.red, got.green, got.blue, got.mx, got.my, got.mz, got.ok);
          end
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done) begin
        if (errors == 0 && shade_queue.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
      end else if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// ===== conductor_fresnel_specular_eval.f =====
design/cfse_pkg.sv
design/cfse_if.sv
design/conductor_fresnel_specular_eval.sv
sim/tb_conductor_fresnel_specular_eval.sv
